// ===== hdl/tbalm_pkg.sv =====
package tbalm_pkg;

    localparam int BANDS_DEF = 3;

    localparam logic [31:0] REF_FLOOR       = 32'd1258291;
    localparam logic [15:0] LEVEL_QUIET     = 16'd65;
    localparam logic [16:0] IDLE_ENV_DECAY  = 17'd52429;
    localparam logic [16:0] IDLE_PEAK_DECAY = 17'd58982;
    localparam logic [15:0] CNT_MAX         = 16'hffff;
    localparam logic signed [63:0] SEC_ROUND = 64'sd536870912;

    localparam logic [2:0] CFG_EMIT_PERIOD = 3'd0;
    localparam logic [2:0] CFG_IDLE_AFTER  = 3'd1;
    localparam logic [2:0] CFG_IDLE_CHECK  = 3'd2;
    localparam logic [2:0] CFG_BAND_GAIN   = 3'd3;
    localparam logic [2:0] CFG_GATE_LEVEL  = 3'd4;
    localparam logic [2:0] CFG_ATTACK      = 3'd5;
    localparam logic [2:0] CFG_RELEASE     = 3'd6;
    localparam logic [2:0] CFG_PEAK_DECAY  = 3'd7;

    typedef struct packed {
        logic               command;
        logic signed [15:0] left_sample;
        logic signed [15:0] right_sample;
    } t_in_item;

    typedef struct packed {
        logic [15:0] level_low;
        logic [15:0] level_mid;
        logic [15:0] level_high;
        logic        from_idle_decay;
    } t_out_item;

    typedef enum logic [4:0] {
        S_IDLE, S_TICK, S_FMUL, S_FACC, S_SEC, S_EMUL, S_EUPD, S_CHK,
        S_GMUL, S_GUPD, S_PMUL, S_PUPD, S_LVL, S_DIV, S_LSTORE,
        S_IMUL, S_IUPD, S_DONE
    } t_state;

    // taps per section: b0 * x, -b0 * x2, -a1 * y1, -a2 * y2
    function automatic logic signed [32:0] filt_coef(input logic [1:0] c,
                                                     input logic [1:0] k);
        logic signed [32:0] r;
        r = '0;
        case (c)
            2'd0: begin
                case (k)
                    2'd0: r = 33'sd4664596;
                    2'd1: r = -33'sd4664596;
                    2'd2: r = 33'sd2137971275;
                    default: r = -33'sd1064412632;
                endcase
            end
            2'd1: begin
                case (k)
                    2'd0: r = 33'sd47824664;
                    2'd1: r = -33'sd47824664;
                    2'd2: r = 33'sd2034280593;
                    default: r = -33'sd978092496;
                endcase
            end
            default: begin
                case (k)
                    2'd0: r = 33'sd244359199;
                    2'd1: r = -33'sd244359199;
                    2'd2: r = 33'sd1172924135;
                    default: r = -33'sd585023426;
                endcase
            end
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/tbalm_stream_if.sv =====
interface tbalm_stream_if #(parameter type t_payload = logic) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source(output valid, output payload, input ready);
    modport sink(input valid, input payload, output ready);
endinterface

// ===== hdl/three_band_audio_level_meter_core.sv =====
// Three-band level meter: stereo frames are mixed to mono, filtered by two-section
// band-pass biquads per band, envelope-followed and scaled against a shared AGC
// reference; millisecond ticks drive the idle decay. One 33x33 multiplier with a
// registered product does every product under a sequencer, and a one-bit-per-cycle
// divider forms the levels. Per band a frame runs eight taps, a product and an
// accumulate each, then rounding and the envelope; when the level update is due,
// each band adds gain and peak products and, unless gated or at full scale, a
// division. A tick steps counters and may decay each band's state. Input is held off
// while an item is in work; a finished result sits in the output register.
module three_band_audio_level_meter_core
    import tbalm_pkg::*;
#(
    parameter int BANDS = BANDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tbalm_stream_if.sink   i_in,
    tbalm_stream_if.source o_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    localparam int BW = (BANDS > 1) ? $clog2(BANDS) : 1;
    localparam logic [BW-1:0] LAST_BAND = BW'(BANDS - 1);

    t_state r_state, n_state;

    logic [9:0]  r_emit_period, r_idle_check;
    logic [13:0] r_idle_after;
    logic [7:0]  r_gain;
    logic [15:0] r_gate, r_attack, r_release, r_decay;

    logic signed [31:0] r_hist [BANDS][6];
    logic [23:0] r_env   [BANDS];
    logic [31:0] r_peak  [BANDS];
    logic [15:0] r_level [BANDS];
    logic [31:0] r_eg    [BANDS];
    logic [15:0] r_since_emit, r_since_data, r_idle_phase;

    logic [BW-1:0] r_band;
    logic [1:0]    r_k;
    logic          r_sec;
    logic [1:0]    r_sub;
    logic signed [31:0] r_x0, r_s1, r_y;
    logic signed [63:0] r_acc;
    logic signed [65:0] r_prod;
    logic [31:0] r_ref;
    logic        r_changed;
    logic [31:0] r_rem;
    logic [15:0] r_quo;
    logic [3:0]  r_dcnt;
    logic        r_idle;
    logic        r_out_valid;
    t_out_item   r_out;

    logic signed [32:0] mul_a, mul_b;
    logic [1:0]  coef_sel;
    logic [2:0]  hidx;
    logic [31:0] y_abs;
    logic [23:0] mag;
    logic signed [24:0] env_diff;
    logic signed [63:0] acc_rnd;
    logic signed [33:0] sec_t;
    logic signed [31:0] sec_y;
    logic        band_last;
    logic [15:0] se_inc, sd_inc, ip_inc;
    logic        quiet;
    logic [31:0] eg_cur, dec_cur, peak_new;
    logic [32:0] rem2;
    logic        load_out;
    logic [15:0] lv_out [3];

    assign coef_sel  = (int'(r_band) >= 2) ? 2'd2 : 2'(r_band);
    assign hidx      = {1'b0, r_k} + (r_sec ? 3'd2 : 3'd0);
    assign y_abs     = r_y[31] ? 32'(-r_y) : 32'(r_y);
    assign mag       = y_abs[31:8];
    assign env_diff  = $signed({1'b0, mag}) - $signed({1'b0, r_env[r_band]});
    assign acc_rnd   = r_acc + SEC_ROUND;
    assign sec_t     = acc_rnd[63:30];
    assign band_last = (r_band == LAST_BAND);
    assign se_inc    = (r_since_emit == CNT_MAX) ? CNT_MAX : r_since_emit + 16'd1;
    assign sd_inc    = (r_since_data == CNT_MAX) ? CNT_MAX : r_since_data + 16'd1;
    assign ip_inc    = (r_idle_phase == CNT_MAX) ? CNT_MAX : r_idle_phase + 16'd1;
    assign eg_cur    = r_eg[r_band];
    assign dec_cur   = r_prod[47:16];
    assign peak_new  = (eg_cur > dec_cur) ? eg_cur : dec_cur;
    assign rem2      = {r_rem, 1'b0};
    assign load_out  = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    // round half up, then saturate to 32 bits
    always_comb begin
        if (sec_t[33:31] == 3'b000 || sec_t[33:31] == 3'b111) begin
            sec_y = sec_t[31:0];
        end else if (!sec_t[33]) begin
            sec_y = 32'sh7fffffff;
        end else begin
            sec_y = 32'sh80000000;
        end
    end

    always_comb begin
        quiet = 1'b1;
        for (int b = 0; b < BANDS; b++) begin
            if (r_level[b] > LEVEL_QUIET) begin
                quiet = 1'b0;
            end
        end
        for (int j = 0; j < 3; j++) begin
            lv_out[j] = '0;
        end
        for (int j = 0; j < 3 && j < BANDS; j++) begin
            lv_out[j] = r_level[j];
        end
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.payload = r_out;

    // sequencer and multiplier operand select
    always_comb begin
        n_state = r_state;
        mul_a   = '0;
        mul_b   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_state = i_in.payload.command ? S_TICK : S_FMUL;
                end
            end
            S_TICK: begin
                if (ip_inc < {6'd0, r_idle_check} || sd_inc < {2'd0, r_idle_after}
                    || quiet) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_IMUL;
                end
            end
            S_FMUL: begin
                mul_a = filt_coef(coef_sel, r_k);
                if (r_k == 2'd0) begin
                    mul_b = r_sec ? 33'(r_s1) : 33'(r_x0);
                end else begin
                    mul_b = 33'(r_hist[r_band][hidx]);
                end
                n_state = S_FACC;
            end
            S_FACC: n_state = (r_k == 2'd3) ? S_SEC : S_FMUL;
            S_SEC:  n_state = r_sec ? S_EMUL : S_FMUL;
            S_EMUL: begin
                mul_a   = $signed({17'd0, (mag > r_env[r_band]) ? r_attack : r_release});
                mul_b   = 33'(env_diff);
                n_state = S_EUPD;
            end
            S_EUPD: n_state = band_last ? S_CHK : S_FMUL;
            S_CHK: begin
                n_state = (r_since_emit < {6'd0, r_emit_period}) ? S_IDLE : S_GMUL;
            end
            S_GMUL: begin
                mul_a   = $signed({9'd0, r_env[r_band]});
                mul_b   = $signed({25'd0, r_gain});
                n_state = S_GUPD;
            end
            S_GUPD: n_state = S_PMUL;
            S_PMUL: begin
                mul_a   = $signed({1'b0, r_peak[r_band]});
                mul_b   = $signed({17'd0, r_decay});
                n_state = S_PUPD;
            end
            S_PUPD: n_state = band_last ? S_LVL : S_GMUL;
            S_LVL: begin
                if (eg_cur < {10'd0, r_gate, 6'd0} || eg_cur >= r_ref) begin
                    n_state = S_LSTORE;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV:  n_state = (r_dcnt == 4'd15) ? S_LSTORE : S_DIV;
            S_LSTORE: begin
                if (!band_last) begin
                    n_state = S_LVL;
                end else if (r_changed || r_quo != r_level[r_band]) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_IMUL: begin
                case (r_sub)
                    2'd0: begin
                        mul_a = $signed({9'd0, r_env[r_band]});
                        mul_b = $signed({16'd0, IDLE_ENV_DECAY});
                    end
                    2'd1: begin
                        mul_a = $signed({1'b0, r_peak[r_band]});
                        mul_b = $signed({16'd0, IDLE_PEAK_DECAY});
                    end
                    default: begin
                        mul_a = $signed({17'd0, r_level[r_band]});
                        mul_b = $signed({16'd0, IDLE_ENV_DECAY});
                    end
                endcase
                n_state = S_IUPD;
            end
            S_IUPD: n_state = (band_last && r_sub == 2'd2) ? S_DONE : S_IMUL;
            S_DONE: n_state = load_out ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit_period <= 10'd66;
            r_idle_after  <= 14'd400;
            r_idle_check  <= 10'd120;
            r_gain        <= 8'd10;
            r_gate        <= 16'd7864;
            r_attack      <= 16'd26214;
            r_release     <= 16'd3277;
            r_decay       <= 16'd65208;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_EMIT_PERIOD: r_emit_period <= i_cfg_data[9:0];
                CFG_IDLE_AFTER:  r_idle_after  <= i_cfg_data[13:0];
                CFG_IDLE_CHECK:  r_idle_check  <= i_cfg_data[9:0];
                CFG_BAND_GAIN:   r_gain        <= i_cfg_data[7:0];
                CFG_GATE_LEVEL:  r_gate        <= i_cfg_data;
                CFG_ATTACK:      r_attack      <= i_cfg_data;
                CFG_RELEASE:     r_release     <= i_cfg_data;
                CFG_PEAK_DECAY:  r_decay       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < BANDS; b++) begin
                for (int h = 0; h < 6; h++) begin
                    r_hist[b][h] <= '0;
                end
                r_env[b]   <= '0;
                r_peak[b]  <= '0;
                r_level[b] <= '0;
            end
            r_since_emit <= '0;
            r_since_data <= '0;
            r_idle_phase <= '0;
            r_band       <= '0;
            r_k          <= '0;
            r_sec        <= 1'b0;
            r_sub        <= '0;
            r_acc        <= '0;
            r_changed    <= 1'b0;
            r_dcnt       <= '0;
            r_idle       <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_band <= '0;
                    r_k    <= '0;
                    r_sec  <= 1'b0;
                    r_sub  <= '0;
                    r_acc  <= '0;
                    r_x0   <= 32'(($signed({i_in.payload.left_sample[15],
                                            i_in.payload.left_sample})
                                  + $signed({i_in.payload.right_sample[15],
                                            i_in.payload.right_sample})) * 32'sd16384);
                end
                S_TICK: begin
                    r_since_emit <= se_inc;
                    r_since_data <= sd_inc;
                    r_idle_phase <= (ip_inc < {6'd0, r_idle_check}) ? ip_inc : 16'd0;
                    r_idle       <= 1'b1;
                end
                S_FACC: begin
                    r_acc <= r_acc + r_prod[63:0];
                    r_k   <= r_k + 2'd1;
                end
                S_SEC: begin
                    r_acc <= '0;
                    r_k   <= '0;
                    r_sec <= ~r_sec;
                    if (!r_sec) begin
                        r_s1 <= sec_y;
                    end else begin
                        r_y <= sec_y;
                        r_hist[r_band][1] <= r_hist[r_band][0];
                        r_hist[r_band][0] <= r_x0;
                        r_hist[r_band][3] <= r_hist[r_band][2];
                        r_hist[r_band][2] <= r_s1;
                        r_hist[r_band][5] <= r_hist[r_band][4];
                        r_hist[r_band][4] <= sec_y;
                    end
                end
                S_EUPD: begin
                    r_env[r_band] <= r_env[r_band] + r_prod[39:16];
                    r_band <= band_last ? '0 : r_band + BW'(1);
                end
                S_CHK: begin
                    r_since_data <= '0;
                    r_ref        <= REF_FLOOR;
                    r_changed    <= 1'b0;
                    r_idle       <= 1'b0;
                    if (r_since_emit >= {6'd0, r_emit_period}) begin
                        r_since_emit <= '0;
                    end
                end
                S_GUPD: r_eg[r_band] <= r_prod[31:0];
                S_PUPD: begin
                    r_peak[r_band] <= peak_new;
                    if (peak_new > r_ref) begin
                        r_ref <= peak_new;
                    end
                    r_band <= band_last ? '0 : r_band + BW'(1);
                end
                S_LVL: begin
                    r_rem  <= eg_cur;
                    r_dcnt <= '0;
                    if (eg_cur < {10'd0, r_gate, 6'd0}) begin
                        r_quo <= '0;
                    end else if (eg_cur >= r_ref) begin
                        r_quo <= 16'hffff;
                    end else begin
                        r_quo <= '0;
                    end
                end
                S_DIV: begin
                    r_dcnt <= r_dcnt + 4'd1;
                    if (rem2 >= {1'b0, r_ref}) begin
                        r_rem <= 32'(rem2 - {1'b0, r_ref});
                        r_quo <= {r_quo[14:0], 1'b1};
                    end else begin
                        r_rem <= rem2[31:0];
                        r_quo <= {r_quo[14:0], 1'b0};
                    end
                end
                S_LSTORE: begin
                    if (r_quo != r_level[r_band]) begin
                        r_changed <= 1'b1;
                    end
                    r_level[r_band] <= r_quo;
                    r_band <= band_last ? '0 : r_band + BW'(1);
                end
                S_IUPD: begin
                    case (r_sub)
                        2'd0:    r_env[r_band]   <= r_prod[39:16];
                        2'd1:    r_peak[r_band]  <= r_prod[47:16];
                        default: r_level[r_band] <= r_prod[31:16];
                    endcase
                    if (r_sub == 2'd2) begin
                        r_sub  <= '0;
                        r_band <= band_last ? '0 : r_band + BW'(1);
                    end else begin
                        r_sub <= r_sub + 2'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // result register parts the output transfer from the sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out.level_low       <= lv_out[0];
            r_out.level_mid       <= lv_out[1];
            r_out.level_high      <= lv_out[2];
            r_out.from_idle_decay <= r_idle;
        end
    end

`ifndef SYNTHESIS
    // restoring division keeps the partial remainder below the divisor
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_rem < r_ref)
        else $error("divider remainder not below reference");

    a_ref_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LVL || r_state == S_DIV) |-> r_ref >= REF_FLOOR)
        else $error("reference below floor");

    a_done_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_DONE)
        else $error("result loaded outside done state");
`endif

endmodule
